// ----- sv/dkar_pkg.sv -----
// shared types, constants and register indexes for the direction key auto-repeat block
`default_nettype none

package dkar_pkg;

    // field widths
    localparam int unsigned DIR_W     = 4;
    localparam int unsigned STICK_W   = 8;
    localparam int unsigned EDGE_W    = 2;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned LEVEL_W   = 9;
    localparam int unsigned MAG_W     = 7;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned OWNER_W   = 3;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;

    // direction bit positions
    localparam int unsigned DIR_UP    = 0;
    localparam int unsigned DIR_DOWN  = 1;
    localparam int unsigned DIR_LEFT  = 2;
    localparam int unsigned DIR_RIGHT = 3;

    // repeat clock owner codes
    localparam logic [OWNER_W-1:0] OWNER_NONE  = 3'd0;
    localparam logic [OWNER_W-1:0] OWNER_UP    = 3'd1;
    localparam logic [OWNER_W-1:0] OWNER_DOWN  = 3'd2;
    localparam logic [OWNER_W-1:0] OWNER_LEFT  = 3'd3;
    localparam logic [OWNER_W-1:0] OWNER_RIGHT = 3'd4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'd131071;
    localparam logic [LEVEL_W-1:0]   LEVEL_FULL  = 9'd256;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN      = 3'd4;

    // configuration reset values
    localparam logic [TICKS_W-1:0] RST_DELAY     = 16'd800;
    localparam logic [TICKS_W-1:0] RST_PERIOD    = 16'd125;
    localparam logic [MAG_W-1:0]   RST_THRESHOLD = 7'd42;
    localparam logic [MAG_W-1:0]   RST_DEAD_ZONE = 7'd8;
    localparam logic [GAIN_W-1:0]  RST_GAIN      = 16'd851;

    // one input frame
    typedef struct packed {
        logic [TICKS_W-1:0]        frame_ticks;
        logic signed [EDGE_W-1:0]  stick_edge_y;
        logic signed [EDGE_W-1:0]  stick_edge_x;
        logic signed [STICK_W-1:0] stick_y;
        logic signed [STICK_W-1:0] stick_x;
        logic [DIR_W-1:0]          dir_held;
        logic [DIR_W-1:0]          dir_pressed;
    } t_item;

    // repeat timing settings
    typedef struct packed {
        logic [TICKS_W-1:0] delay;
        logic [TICKS_W-1:0] period;
        logic [MAG_W-1:0]   threshold;
    } t_timing;

endpackage

`default_nettype wire

// ----- sv/dkar_level.sv -----
// dead-zone scaled stick level in Q1.8, saturated at full scale
`default_nettype none

module dkar_level (
    input  wire logic signed [dkar_pkg::STICK_W-1:0] i_mag,
    input  wire logic [dkar_pkg::MAG_W-1:0]          i_dead_zone,
    input  wire logic [dkar_pkg::GAIN_W-1:0]         i_gain,
    output logic [dkar_pkg::LEVEL_W-1:0]             o_level
);

    localparam int unsigned PROD_W = dkar_pkg::MAG_W + dkar_pkg::GAIN_W;
    localparam int unsigned SHR_W  = PROD_W - 8;

    logic signed [dkar_pkg::STICK_W:0] diff;
    logic [PROD_W-1:0]                 prod;
    logic [SHR_W-1:0]                  scaled;

    // distance past the dead zone
    assign diff = $signed({i_mag[dkar_pkg::STICK_W-1], i_mag})
                - $signed({2'b00, i_dead_zone});

    assign prod   = PROD_W'(diff[dkar_pkg::MAG_W-1:0]) * PROD_W'(i_gain);
    assign scaled = prod[PROD_W-1:8];

    // zero inside the dead zone, clamp at full
    always_comb begin
        if (diff[dkar_pkg::STICK_W] || diff == '0) begin
            o_level = '0;
        end else if (scaled > SHR_W'(dkar_pkg::LEVEL_FULL)) begin
            o_level = dkar_pkg::LEVEL_FULL;
        end else begin
            o_level = scaled[dkar_pkg::LEVEL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dkar_judge.sv -----
// repeat clock state and the per-direction step decision for one frame
`default_nettype none

module dkar_judge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire dkar_pkg::t_item             i_item,
    input  wire dkar_pkg::t_timing           i_timing,
    output logic [dkar_pkg::DIR_W-1:0]       o_steps
);

    // how the repeat clock leaves the frame
    localparam logic [1:0] CLK_KEEP  = 2'd0;
    localparam logic [1:0] CLK_ZERO  = 2'd1;
    localparam logic [1:0] CLK_TIMER = 2'd2;

    logic [dkar_pkg::OWNER_W-1:0]   r_owner, n_owner;
    logic [dkar_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                           r_in_repeat, n_in_repeat;

    logic [dkar_pkg::DIR_W-1:0]     pressed, held;
    logic signed [dkar_pkg::STICK_W:0] sx9, sy9, th9;

    logic [dkar_pkg::ELAPSED_W:0]   sum;
    logic [dkar_pkg::ELAPSED_W-1:0] sat, wait_t, rem;
    logic                           hit;

    logic [1:0] clk_mode;

    // pressed and held per direction from buttons and stick
    assign sx9 = $signed({i_item.stick_x[dkar_pkg::STICK_W-1], i_item.stick_x});
    assign sy9 = $signed({i_item.stick_y[dkar_pkg::STICK_W-1], i_item.stick_y});
    assign th9 = $signed({2'b00, i_timing.threshold});

    always_comb begin
        pressed = i_item.dir_pressed;
        held    = i_item.dir_held;
        if (i_item.stick_edge_y == 2'b01)   pressed[dkar_pkg::DIR_UP]    = 1'b1;
        if (i_item.stick_edge_y[1])         pressed[dkar_pkg::DIR_DOWN]  = 1'b1;
        if (i_item.stick_edge_x[1])         pressed[dkar_pkg::DIR_LEFT]  = 1'b1;
        if (i_item.stick_edge_x == 2'b01)   pressed[dkar_pkg::DIR_RIGHT] = 1'b1;
        if (sy9 > th9)                      held[dkar_pkg::DIR_UP]       = 1'b1;
        if (sy9 < -th9)                     held[dkar_pkg::DIR_DOWN]     = 1'b1;
        if (sx9 < -th9)                     held[dkar_pkg::DIR_LEFT]     = 1'b1;
        if (sx9 > th9)                      held[dkar_pkg::DIR_RIGHT]    = 1'b1;
    end

    // timer advance; only the owner at frame start can run it, so it works on the stored state
    assign sum    = {1'b0, r_elapsed} + {2'b00, i_item.frame_ticks};
    assign sat    = sum[dkar_pkg::ELAPSED_W] ? dkar_pkg::ELAPSED_MAX
                                             : sum[dkar_pkg::ELAPSED_W-1:0];
    assign wait_t = {1'b0, r_in_repeat ? i_timing.period : i_timing.delay};
    assign hit    = (sat >= wait_t);
    assign rem    = sat - wait_t;

    // directions judged in order up, down, left, right
    always_comb begin
        logic [dkar_pkg::OWNER_W-1:0] code;
        n_owner  = r_owner;
        clk_mode = CLK_KEEP;
        o_steps  = '0;
        for (int d = 0; d < dkar_pkg::DIR_W; d++) begin
            code = dkar_pkg::OWNER_W'(d + 1);
            if (pressed[d]) begin
                n_owner    = code;
                clk_mode   = CLK_ZERO;
                o_steps[d] = 1'b1;
            end else if (n_owner == dkar_pkg::OWNER_NONE && held[d]) begin
                n_owner  = code;
                clk_mode = CLK_ZERO;
            end else if (n_owner != code) begin
                n_owner = n_owner;
            end else if (!held[d]) begin
                n_owner = dkar_pkg::OWNER_NONE;
            end else begin
                clk_mode   = CLK_TIMER;
                o_steps[d] = hit;
            end
        end
    end

    // next repeat clock
    always_comb begin
        case (clk_mode)
            CLK_ZERO: begin
                n_elapsed   = '0;
                n_in_repeat = 1'b0;
            end
            CLK_TIMER: begin
                n_elapsed   = hit ? rem : sat;
                n_in_repeat = hit | r_in_repeat;
            end
            default: begin
                n_elapsed   = r_elapsed;
                n_in_repeat = r_in_repeat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= dkar_pkg::OWNER_NONE;
            r_elapsed   <= '0;
            r_in_repeat <= 1'b0;
        end else if (i_en) begin
            r_owner     <= n_owner;
            r_elapsed   <= n_elapsed;
            r_in_repeat <= n_in_repeat;
        end
    end

endmodule

`default_nettype wire

// ----- sv/direction_key_auto_repeat_top.sv -----
// top level: stream ports, configuration registers, input and result registers
`default_nettype none

// Menu direction auto-repeat. Each frame transfer carries the direction
// buttons, the stick and the elapsed milliseconds; each result transfer
// carries four step pulses and the up and down hold levels. Throughput is one
// frame per clock while the result output is not stalled. A result is held in
// one input register, then one result register, and comes from the single pass
// that judges all four directions against the shared repeat clock. Write
// configuration only while no frame is in flight; the registers reset to
// delay 800, period 125, threshold 42, dead zone 8 and gain 851.
module direction_key_auto_repeat_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [dkar_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [dkar_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // frame input
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // dir_pressed[3:0], dir_held[7:4], stick_x[15:8], stick_y[23:16],
    // stick_edge_x[25:24], stick_edge_y[27:26], frame_ticks[43:28], zero[47:44]
    input  wire logic [dkar_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result output
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // step_up[0], step_down[1], step_left[2], step_right[3],
    // up_level[12:4], down_level[21:13], zero[23:22]
    output logic [dkar_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    logic [dkar_pkg::TICKS_W-1:0] r_delay, r_period;
    logic [dkar_pkg::MAG_W-1:0]   r_threshold, r_dead_zone;
    logic [dkar_pkg::GAIN_W-1:0]  r_gain;

    logic              r_in_valid;
    dkar_pkg::t_item   r_in_item;
    logic              r_out_valid;
    logic [dkar_pkg::OUT_TDATA_W-1:0] r_out_tdata;

    logic              advance;
    dkar_pkg::t_timing timing;
    logic [dkar_pkg::DIR_W-1:0]   steps;
    logic signed [dkar_pkg::STICK_W-1:0] neg_y;
    logic [dkar_pkg::LEVEL_W-1:0] stick_up, stick_down, up_level, down_level;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= dkar_pkg::RST_DELAY;
            r_period    <= dkar_pkg::RST_PERIOD;
            r_threshold <= dkar_pkg::RST_THRESHOLD;
            r_dead_zone <= dkar_pkg::RST_DEAD_ZONE;
            r_gain      <= dkar_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dkar_pkg::REG_DELAY:     r_delay     <= i_cfg_wdata;
                dkar_pkg::REG_PERIOD:    r_period    <= i_cfg_wdata;
                dkar_pkg::REG_THRESHOLD: r_threshold <= i_cfg_wdata[dkar_pkg::MAG_W-1:0];
                dkar_pkg::REG_DEAD_ZONE: r_dead_zone <= i_cfg_wdata[dkar_pkg::MAG_W-1:0];
                dkar_pkg::REG_GAIN:      r_gain      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= s_axis_tdata[$bits(dkar_pkg::t_item)-1:0];
        end
    end

    // step decision
    assign timing.delay     = r_delay;
    assign timing.period    = r_period;
    assign timing.threshold = r_threshold;

    dkar_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && advance),
        .i_item   (r_in_item),
        .i_timing (timing),
        .o_steps  (steps)
    );

    // hold levels; negated stick saturates at the top
    assign neg_y = (r_in_item.stick_y == 8'sh80) ? 8'sd127 : -r_in_item.stick_y;

    dkar_level u_level_up (
        .i_mag       (r_in_item.stick_y),
        .i_dead_zone (r_dead_zone),
        .i_gain      (r_gain),
        .o_level     (stick_up)
    );

    dkar_level u_level_down (
        .i_mag       (neg_y),
        .i_dead_zone (r_dead_zone),
        .i_gain      (r_gain),
        .o_level     (stick_down)
    );

    assign up_level   = r_in_item.dir_held[dkar_pkg::DIR_UP]   ? dkar_pkg::LEVEL_FULL : stick_up;
    assign down_level = r_in_item.dir_held[dkar_pkg::DIR_DOWN] ? dkar_pkg::LEVEL_FULL
                                                                : stick_down;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_tdata <= {2'b00, down_level, up_level, steps};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule

`default_nettype wire
